// ----- sv/segment_rect_intersect_top_assert.svh -----
// assertion macros shared by the checker
`ifndef SEGMENT_RECT_INTERSECT_TOP_ASSERT_SVH
`define SEGMENT_RECT_INTERSECT_TOP_ASSERT_SVH

// same-cycle implication, ignored while reset is held
`define SRI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("segment_rect_intersect_top: assertion failed");

// next-cycle implication, ignored while reset is held
`define SRI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("segment_rect_intersect_top: assertion failed");

// next-cycle implication that also watches the reset itself
`define SRI_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("segment_rect_intersect_top: reset assertion failed");

`endif

// ----- sv/sri_pkg.sv -----
package sri_pkg;

    localparam int CW = 32;
    localparam int PW = 2 * CW + 3;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [CW:0]   diff_t;
    typedef logic signed [CW+1:0] den_t;
    typedef logic signed [PW-1:0] prod_t;

    typedef enum logic [2:0] {
        REG_LEFT,
        REG_RIGHT,
        REG_TOP,
        REG_BOTTOM,
        REG_EPS
    } reg_idx_t;

    // one axis after parallel test and entry/exit selection
    typedef struct packed {
        logic  par;
        logic  par_rej;
        diff_t en;
        diff_t xn;
        den_t  den;
    } axis_t;

endpackage

// ----- sv/sri_xmul.sv -----
module sri_xmul import sri_pkg::*; (
    input  logic  aclk,
    input  logic  en,
    input  diff_t an,
    input  den_t  bd,
    input  diff_t bn,
    input  den_t  ad,
    output prod_t pa,
    output prod_t pb
);

    prod_t pa_reg, pb_reg;
    prod_t pa_next, pb_next;

    always_comb begin
        pa_next = prod_t'(an) * prod_t'(bd);
        pb_next = prod_t'(bn) * prod_t'(ad);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
    end

    assign pa = pa_reg;
    assign pb = pb_reg;

endmodule

// ----- sv/segment_rect_intersect_top.sv -----
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+---------------------------------
// request   | in        | s_valid / s_ready  | s_start_x s_start_y s_end_x s_end_y
// result    | out       | m_valid / m_ready  | m_hit
// config    | in        | cfg_we             | cfg_index cfg_wdata
//
// one request per cycle sustained while m_ready stays high; a taken request reaches m_valid
// through four register stages in order: differences, axis select, cross
// products, final compare
// aresetn synchronous active low clears stage valids and resets the configuration registers
// a stalled result holds its stage; earlier stages fill behind it
module segment_rect_intersect_top import sri_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [CW-1:0] cfg_wdata,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [CW-1:0] s_start_x,
    input  logic [CW-1:0] s_start_y,
    input  logic [CW-1:0] s_end_x,
    input  logic [CW-1:0] s_end_y,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_hit
);

    // configuration registers
    coord_t      left_reg, right_reg, top_reg, bottom_reg;
    logic [15:0] eps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            right_reg  <= '0;
            top_reg    <= '0;
            bottom_reg <= '0;
            eps_reg    <= 16'd1;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_LEFT:   left_reg   <= cfg_wdata[CW-1:0];
                REG_RIGHT:  right_reg  <= cfg_wdata[CW-1:0];
                REG_TOP:    top_reg    <= cfg_wdata[CW-1:0];
                REG_BOTTOM: bottom_reg <= cfg_wdata[CW-1:0];
                REG_EPS:    eps_reg    <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // stage valids and move enables, a stage moves when the next has room
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic mv1, mv2, mv3, mv4;

    assign mv4     = !v4_reg || m_ready;
    assign mv3     = !v3_reg || mv4;
    assign mv2     = !v2_reg || mv3;
    assign mv1     = !v1_reg || mv2;
    assign s_ready = mv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (mv1) v1_reg <= s_valid;
            if (mv2) v2_reg <= v1_reg;
            if (mv3) v3_reg <= v2_reg;
            if (mv4) v4_reg <= v3_reg;
        end
    end

    // stage 1: direction, edge distances, endpoint inside test
    coord_t sx, sy, ex, ey;
    diff_t  dx_next, dy_next, ql_next, qr_next, qt_next, qb_next;
    logic   inside_next;
    diff_t  dx_reg, dy_reg, ql_reg, qr_reg, qt_reg, qb_reg;
    logic   inside_reg;

    assign sx = s_start_x[CW-1:0];
    assign sy = s_start_y[CW-1:0];
    assign ex = s_end_x[CW-1:0];
    assign ey = s_end_y[CW-1:0];

    always_comb begin
        dx_next = diff_t'(ex) - diff_t'(sx);
        dy_next = diff_t'(ey) - diff_t'(sy);
        ql_next = diff_t'(sx) - diff_t'(left_reg);
        qr_next = diff_t'(right_reg) - diff_t'(sx);
        qt_next = diff_t'(sy) - diff_t'(top_reg);
        qb_next = diff_t'(bottom_reg) - diff_t'(sy);
        inside_next =
            (sx >= left_reg && sx <= right_reg && sy >= top_reg && sy <= bottom_reg) ||
            (ex >= left_reg && ex <= right_reg && ey >= top_reg && ey <= bottom_reg);
    end

    always_ff @(posedge aclk) begin
        if (mv1) begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            ql_reg     <= ql_next;
            qr_reg     <= qr_next;
            qt_reg     <= qt_next;
            qb_reg     <= qb_next;
            inside_reg <= inside_next;
        end
    end

    // stage 2: per axis parallel test and entry / exit ratio selection
    function automatic axis_t axis_sel(diff_t d, diff_t qlo, diff_t qhi, logic [15:0] eps);
        axis_t a;
        den_t  m;
        m         = d[CW] ? -den_t'(d) : den_t'(d);
        a.par     = (d == '0) || (m < den_t'({1'b0, eps}));
        a.par_rej = a.par && (qlo[CW] || qhi[CW]);
        a.den     = m;
        // moving towards larger values enters at the low edge
        a.en      = d[CW] ? -qhi : -qlo;
        a.xn      = d[CW] ? qlo : qhi;
        return a;
    endfunction

    axis_t ax_reg, ay_reg;
    logic  inside2_reg;

    always_ff @(posedge aclk) begin
        if (mv2) begin
            ax_reg      <= axis_sel(dx_reg, ql_reg, qr_reg, eps_reg);
            ay_reg      <= axis_sel(dy_reg, qt_reg, qb_reg, eps_reg);
            inside2_reg <= inside_reg;
        end
    end

    // stage 3: cross products for the mixed-axis compares, single-axis checks
    prod_t p_exy, p_yex, p_eyx, p_xey;
    logic  simple_next, simple_reg, cross_reg, inside3_reg;

    // x entry against y exit
    sri_xmul u_mul_a (
        .aclk (aclk),
        .en   (mv3),
        .an   (ax_reg.en),
        .bd   (ay_reg.den),
        .bn   (ay_reg.xn),
        .ad   (ax_reg.den),
        .pa   (p_exy),
        .pb   (p_yex)
    );

    // y entry against x exit
    sri_xmul u_mul_b (
        .aclk (aclk),
        .en   (mv3),
        .an   (ay_reg.en),
        .bd   (ax_reg.den),
        .bn   (ax_reg.xn),
        .ad   (ay_reg.den),
        .pa   (p_eyx),
        .pb   (p_xey)
    );

    // entry at most 1 and before its own exit, exit not behind start
    always_comb begin
        simple_next = !ax_reg.par_rej && !ay_reg.par_rej;
        if (!ax_reg.par) begin
            simple_next = simple_next && (ax_reg.en <= ax_reg.xn) &&
                          (den_t'(ax_reg.en) <= ax_reg.den) && !ax_reg.xn[CW];
        end
        if (!ay_reg.par) begin
            simple_next = simple_next && (ay_reg.en <= ay_reg.xn) &&
                          (den_t'(ay_reg.en) <= ay_reg.den) && !ay_reg.xn[CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (mv3) begin
            simple_reg  <= simple_next;
            cross_reg   <= !ax_reg.par && !ay_reg.par;
            inside3_reg <= inside2_reg;
        end
    end

    // stage 4: final decision into the output register
    logic hit_next, hit_reg;

    assign hit_next = inside3_reg ||
                      (simple_reg && (!cross_reg || ((p_exy <= p_yex) && (p_eyx <= p_xey))));

    always_ff @(posedge aclk) begin
        if (mv4) begin
            hit_reg <= hit_next;
        end
    end

    assign m_valid = v4_reg;
    assign m_hit   = hit_reg;

endmodule

// ----- sv/sri_checker.sv -----
`include "segment_rect_intersect_top_assert.svh"

module sri_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_hit
);

    // a waiting result keeps its value
    `SRI_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_hit))
    // no stall at the output means room at the input
    `SRI_ASSERT_NOW(a_flow, m_ready, s_ready)
    // an empty output stage never blocks requests
    `SRI_ASSERT_NOW(a_empty, !m_valid, s_ready)
    // reset empties the pipeline
    `SRI_ASSERT_RST(a_rst, !aresetn, !m_valid)

endmodule

bind segment_rect_intersect_top sri_checker u_sri_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_hit   (m_hit)
);
